// ===== rtl/multi_channel_volume_fader_assert.svh =====
// Assertion macros for the multi-channel volume fader.
// Included by the top level; no other dependencies.
`ifndef MULTI_CHANNEL_VOLUME_FADER_ASSERT_SVH
`define MULTI_CHANNEL_VOLUME_FADER_ASSERT_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle.
`define MCVF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Expression never holds.
`define MCVF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`else

`define MCVF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define MCVF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/mcvf_pkg.sv =====
// Shared types and constants for the multi-channel volume fader.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mcvf_pkg;

	typedef enum logic [2:0] {
		MODE_STANDBY  = 3'd0,
		MODE_PLAY     = 3'd1,
		MODE_FADE_IN  = 3'd2,
		MODE_FADE_OUT = 3'd3,
		MODE_STOP     = 3'd4
	} mode_t;

	localparam int STEP_W   = 9;
	localparam int MP_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN_STEP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_STEP     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MASTER        = 2'd3;

	localparam logic [STEP_W-1:0] FADE_IN_RST  = 9'd4;
	localparam logic [STEP_W-1:0] FADE_OUT_RST = 9'd2;
	localparam logic [STEP_W-1:0] STOP_RST     = 9'd32;
	localparam logic [MP_W-1:0]   MASTER_RST   = 7'd50;

	// scale = floor(255 * percent / 100) taken as percent * 1336965 >> 19
	localparam int SCALE_W     = 9;
	localparam int RECIP_W     = 21;
	localparam int SCALE_SHIFT = 19;
	localparam logic [RECIP_W-1:0] SCALE_RECIP = 21'd1336965;

	// quotient bits of scale * level / full scale (scale tops out at 323)
	localparam int GAIN_QB = 9;
	localparam int GAIN_W  = 8;
	localparam logic [GAIN_QB-1:0] GAIN_MAX = 9'd255;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;
	localparam int CH_W       = 4;
	localparam int MAX_REPORT = 16;
	localparam logic [1:0] QUEUE_DEPTH = 2'd2;

	typedef struct packed {
		logic            play;
		logic            hit;
		logic [CH_W-1:0] track;
		logic            soft_out;
		logic            instant;
		logic            cut;
	} play_cmd_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		mode_t           mode;
		logic            stop;
		logic            start;
		logic            last;
	} res_meta_t;

endpackage

`default_nettype wire

// ===== rtl/mcvf_front.sv =====
// Front end: accepts input beats, decodes them into commands and queues them.
// Depends on mcvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcvf_front import mcvf_pkg::*; #(
	parameter int CHANNELS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic                 s_axis_tuser,
	output logic                      q_valid,
	output play_cmd_t                 q_cmd,
	input  wire logic                 q_ready
);

	localparam int CMP_W = 7;

	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	play_cmd_t  slot_q [2];
	play_cmd_t  dec;
	logic       push;
	logic       pop;

	always_comb begin
		dec.play     = s_axis_tuser;
		dec.track    = s_axis_tdata[3:0];
		dec.hit      = s_axis_tdata[4] && ({3'b000, s_axis_tdata[3:0]} < CMP_W'(CHANNELS));
		dec.soft_out = s_axis_tdata[5];
		dec.instant  = s_axis_tdata[6];
		dec.cut      = s_axis_tdata[7];
	end

	assign s_axis_tready = cnt_q != QUEUE_DEPTH;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = cnt_q != 2'd0;
	assign pop           = q_valid && q_ready;
	assign q_cmd         = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= dec;
	end

endmodule

`default_nettype wire

// ===== rtl/mcvf_back.sv =====
// Back end: sweeps all channels for one command, one channel a cycle while
// not stalled, reading and writing the channel state memory. Depends on mcvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcvf_back import mcvf_pkg::*; #(
	parameter int CHANNELS   = 16,
	parameter int FULL_SCALE = 256
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	input  wire play_cmd_t                    q_cmd,
	output logic                              q_ready,
	input  wire logic                         adv,
	input  wire logic [STEP_W-1:0]            fade_in_step,
	input  wire logic [STEP_W-1:0]            fade_out_step,
	input  wire logic [STEP_W-1:0]            stop_step,
	output logic                              res_valid,
	output res_meta_t                         res_meta,
	output logic [$clog2(FULL_SCALE+1)-1:0]   res_level
);

	localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int LW       = $clog2(FULL_SCALE + 1);
	localparam int SW       = ((LW > STEP_W) ? LW : STEP_W) + 2;
	localparam int REPORTED = (CHANNELS < MAX_REPORT) ? CHANNELS : MAX_REPORT;
	localparam logic [LW-1:0] FULL_LV = LW'(FULL_SCALE);

	logic              busy_q;
	play_cmd_t         cmd_q;
	logic [CW-1:0]     ch_q;
	logic              issue;
	logic              sweep_end;

	mode_t             mode_mem [CHANNELS];
	logic [LW-1:0]     lvl_mem  [CHANNELS];
	logic [CHANNELS-1:0] vld_q;

	logic              vld_s1;
	logic [CW-1:0]     ch_s1;
	play_cmd_t         cmd_s1;
	mode_t             mode_s1;
	logic [LW-1:0]     lvl_s1;

	logic              wr_en;
	mode_t             new_mode;
	logic [LW-1:0]     new_lvl;
	logic              stop_ev;
	logic              start_ev;
	logic              sounding;
	logic signed [SW-1:0] sum;

	assign issue     = busy_q && adv;
	assign sweep_end = ch_q == CW'(CHANNELS - 1);
	assign q_ready   = !busy_q || (issue && sweep_end);
	assign wr_en     = adv && vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ch_q   <= '0;
		end else if (q_valid && q_ready) begin
			busy_q <= 1'b1;
			ch_q   <= '0;
		end else if (issue) begin
			if (sweep_end)
				busy_q <= 1'b0;
			else
				ch_q <= ch_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready)
			cmd_q <= q_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q  <= '0;
		end else begin
			if (adv)
				vld_s1 <= issue;
			if (wr_en)
				vld_q[ch_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mode_mem[ch_s1] <= new_mode;
			lvl_mem[ch_s1]  <= new_lvl;
		end
	end

	// registered read; forward the write-back when it hits the same channel
	always_ff @(posedge clk) begin
		if (issue) begin
			ch_s1  <= ch_q;
			cmd_s1 <= cmd_q;
			if (wr_en && ch_s1 == ch_q) begin
				mode_s1 <= new_mode;
				lvl_s1  <= new_lvl;
			end else if (vld_q[ch_q]) begin
				mode_s1 <= mode_mem[ch_q];
				lvl_s1  <= lvl_mem[ch_q];
			end else begin
				mode_s1 <= MODE_STANDBY;
				lvl_s1  <= '0;
			end
		end
	end

	always_comb begin
		new_mode = mode_s1;
		new_lvl  = lvl_s1;
		stop_ev  = 1'b0;
		start_ev = 1'b0;
		sounding = 1'b0;
		sum      = $signed(SW'(lvl_s1));
		if (!cmd_s1.play) begin
			case (mode_s1)
				MODE_FADE_IN:  sum = sum + $signed(SW'(fade_in_step));
				MODE_FADE_OUT: sum = sum - $signed(SW'(fade_out_step));
				MODE_STOP:     sum = sum - $signed(SW'(stop_step));
				default:       sum = sum;
			endcase
			if (sum <= $signed(SW'(0))) begin
				new_lvl  = '0;
				stop_ev  = mode_s1 != MODE_STANDBY;
				new_mode = MODE_STANDBY;
			end else if (sum >= $signed(SW'(FULL_SCALE))) begin
				new_lvl  = FULL_LV;
				new_mode = MODE_PLAY;
			end else begin
				new_lvl = LW'(sum);
			end
		end else begin
			sounding = (lvl_s1 != '0) || (mode_s1 != MODE_STANDBY);
			if (lvl_s1 != '0)
				new_mode = cmd_s1.soft_out ? MODE_FADE_OUT : MODE_STOP;
			if (cmd_s1.cut) begin
				stop_ev  = sounding;
				new_lvl  = '0;
				new_mode = MODE_STANDBY;
			end
			// restart the chosen track, dropping it to zero first if it sounds
			if (cmd_s1.hit && CW'(cmd_s1.track) == ch_s1) begin
				if (new_lvl != '0) begin
					stop_ev = 1'b1;
					new_lvl = '0;
				end
				start_ev = 1'b1;
				if (cmd_s1.instant) begin
					new_mode = MODE_PLAY;
					new_lvl  = FULL_LV;
				end else begin
					new_mode = MODE_FADE_IN;
				end
			end
		end
	end

	assign res_valid        = vld_s1 && ({1'b0, ch_s1} < (CW + 1)'(REPORTED));
	assign res_meta.channel = CH_W'(ch_s1);
	assign res_meta.mode    = new_mode;
	assign res_meta.stop    = stop_ev;
	assign res_meta.start   = start_ev;
	assign res_meta.last    = ch_s1 == CW'(REPORTED - 1);
	assign res_level        = new_lvl;

endmodule

`default_nettype wire

// ===== rtl/mcvf_gain.sv =====
// Gain path: scale * level / full scale through a multiplier and a reciprocal
// multiplication, then the output register. Depends on mcvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcvf_gain import mcvf_pkg::*; #(
	parameter int FULL_SCALE = 256
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [MP_W-1:0]            master_percent,
	input  wire logic                       in_valid,
	input  wire res_meta_t                  in_meta,
	input  wire logic [$clog2(FULL_SCALE+1)-1:0] in_level,
	input  wire logic                       out_ready,
	output logic                            adv,
	output logic                            out_valid,
	output res_meta_t                       out_meta,
	output logic [GAIN_W-1:0]               out_gain
);

	localparam int LW    = $clog2(FULL_SCALE + 1);
	localparam int PW    = LW + SCALE_W;
	localparam int QB    = GAIN_QB;
	localparam int MW    = MP_W + RECIP_W;
	localparam int FS_LG = $clog2(FULL_SCALE);
	localparam int RSH   = PW + FS_LG;
	localparam int QPW   = 2 * PW + 1;
	// ceil(2^RSH / full scale): exact floor division for every PW-bit product
	localparam longint unsigned FS_RECIP_L =
		((64'd1 << RSH) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
	localparam logic [PW:0] FS_RECIP = (PW + 1)'(FS_RECIP_L);

	logic [MW-1:0]      scale_prod;
	logic [SCALE_W-1:0] scale_q;

	logic               vld_s1;
	logic [PW-1:0]      prod_s1;
	res_meta_t          meta_s1;

	logic [QPW-1:0]     quo_prod;
	logic [QB-1:0]      quo_fin;

	logic               out_vld_q;
	res_meta_t          out_meta_q;
	logic [GAIN_W-1:0]  out_gain_q;

	assign scale_prod = MW'(master_percent) * MW'(SCALE_RECIP);

	always_ff @(posedge clk) begin
		scale_q <= scale_prod[SCALE_SHIFT +: SCALE_W];
	end

	assign adv = !out_vld_q || out_ready;

	assign quo_prod = QPW'(prod_s1) * QPW'(FS_RECIP);
	assign quo_fin  = quo_prod[RSH +: QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1    <= PW'(scale_q) * PW'(in_level);
			meta_s1    <= in_meta;
			out_meta_q <= meta_s1;
			out_gain_q <= (quo_fin > GAIN_MAX) ? GAIN_MAX[GAIN_W-1:0] : quo_fin[GAIN_W-1:0];
		end
	end

	assign out_valid = out_vld_q;
	assign out_meta  = out_meta_q;
	assign out_gain  = out_gain_q;

endmodule

`default_nettype wire

// ===== rtl/multi_channel_volume_fader.sv =====
// Top level of the multi-channel volume fader: configuration registers, front end,
// channel sweep and gain path. Depends on mcvf_front, mcvf_back, mcvf_gain, mcvf_pkg and the assert header.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_channel_volume_fader_assert.svh"

// Each beat is a tick (tuser 0) that moves every channel by its mode, or a play
// command (tuser 1) that sends sounding channels out and starts a track. Every
// beat yields one result per channel for the first sixteen channels, in channel
// order, tlast on the final one. The back end visits one channel per cycle
// through the single read and write port of the channel state memory, so a beat
// occupies it for one visit per channel; each result then passes the channel
// read register, the level product register and the output register, behind
// the level multiplier and the reciprocal divide by full scale. A two-entry
// command queue lets input beats be taken while the sweep runs, and output
// back-pressure stalls the sweep. Channel state is valid from reset on; there
// is no clearing pass. Configuration writes are taken every cycle and should
// only be made while the block is idle.
module multi_channel_volume_fader import mcvf_pkg::*; #(
	parameter int CHANNELS   = 16,
	parameter int FULL_SCALE = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// [3:0] track, [4] track_valid, [5] soft_out, [6] instant_in, [7] hard_cut
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [0] cmd
	input  wire logic                  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [3:0] channel, [11:4] gain, [14:12] mode, [15] stop_event,
	// [16] start_event, [23:17] zero
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                       m_axis_tlast,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int LW       = $clog2(FULL_SCALE + 1);
	localparam int REPORTED = (CHANNELS < MAX_REPORT) ? CHANNELS : MAX_REPORT;

	logic [STEP_W-1:0] fade_in_q;
	logic [STEP_W-1:0] fade_out_q;
	logic [STEP_W-1:0] stop_q;
	logic [MP_W-1:0]   master_q;

	logic              q_valid;
	play_cmd_t         q_cmd;
	logic              q_ready;
	logic              adv;
	logic              res_valid;
	res_meta_t         res_meta;
	logic [LW-1:0]     res_level;
	res_meta_t         out_meta;
	logic [GAIN_W-1:0] out_gain;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_in_q  <= FADE_IN_RST;
			fade_out_q <= FADE_OUT_RST;
			stop_q     <= STOP_RST;
			master_q   <= MASTER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FADE_IN_STEP:  fade_in_q  <= cfg_data;
				CFG_FADE_OUT_STEP: fade_out_q <= cfg_data;
				CFG_STOP_STEP:     stop_q     <= cfg_data;
				CFG_MASTER:        master_q   <= cfg_data[MP_W-1:0];
				default:           master_q   <= master_q;
			endcase
		end
	end

	mcvf_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_ready      (q_ready)
	);

	mcvf_back #(
		.CHANNELS  (CHANNELS),
		.FULL_SCALE(FULL_SCALE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_ready      (q_ready),
		.adv          (adv),
		.fade_in_step (fade_in_q),
		.fade_out_step(fade_out_q),
		.stop_step    (stop_q),
		.res_valid    (res_valid),
		.res_meta     (res_meta),
		.res_level    (res_level)
	);

	mcvf_gain #(
		.FULL_SCALE(FULL_SCALE)
	) u_gain (
		.clk           (clk),
		.arst_n        (arst_n),
		.master_percent(master_q),
		.in_valid      (res_valid),
		.in_meta       (res_meta),
		.in_level      (res_level),
		.out_ready     (m_axis_tready),
		.adv           (adv),
		.out_valid     (m_axis_tvalid),
		.out_meta      (out_meta),
		.out_gain      (out_gain)
	);

	assign m_axis_tdata = {7'b0000000, out_meta.start, out_meta.stop, out_meta.mode,
		out_gain, out_meta.channel};
	assign m_axis_tlast = out_meta.last;

	`MCVF_ASSERT_IMPL(a_last_channel, clk, arst_n, m_axis_tvalid && m_axis_tlast, out_meta.channel == CH_W'(REPORTED - 1), "tlast on a channel other than the final reported one")
	`MCVF_ASSERT_IMPL(a_standby_silent, clk, arst_n, m_axis_tvalid && out_meta.mode == MODE_STANDBY, out_gain == '0, "standby channel reports a non-zero gain")
	`MCVF_ASSERT_IMPL(a_start_mode, clk, arst_n, m_axis_tvalid && out_meta.start, out_meta.mode == MODE_PLAY || out_meta.mode == MODE_FADE_IN, "start event without play or fade-in")
	`MCVF_ASSERT_NEVER(a_stop_standby, clk, arst_n, m_axis_tvalid && out_meta.stop && !out_meta.start && out_meta.mode != MODE_STANDBY, "stop event left a channel active")

endmodule

`default_nettype wire

// ===== test/mcvf_checker.sv =====
// Scoreboard for the multi-channel volume fader: watches the input, result and
// register-write channels, predicts every channel report and compares it.
// Depends on mcvf_pkg.
`timescale 1ns / 1ps

module mcvf_checker import mcvf_pkg::*; #(
	parameter int CHANNELS   = 16,
	parameter int FULL_SCALE = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	localparam int REPORTED = (CHANNELS < MAX_REPORT) ? CHANNELS : MAX_REPORT;

	typedef struct {
		logic [CH_W-1:0]   channel;
		logic [GAIN_W-1:0] gain;
		mode_t             mode;
		logic              halted;
		logic              started;
		logic              last;
	} chan_report_t;

	chan_report_t gain_reports[$];

	mode_t          ch_mode[CHANNELS];
	int             ch_level[CHANNELS];
	logic           halted[CHANNELS];
	logic           started[CHANNELS];
	logic [STEP_W-1:0] rise_step, fall_step, halt_step;
	logic [MP_W-1:0]   master_pct;

	function automatic void check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	task automatic advance_fades();
		int    lv;
		mode_t m;
		for (int i = 0; i < CHANNELS; i++) begin
			lv = ch_level[i];
			m  = ch_mode[i];
			case (m)
				MODE_FADE_IN:  lv += rise_step;
				MODE_FADE_OUT: lv -= fall_step;
				MODE_STOP:     lv -= halt_step;
				default: ;
			endcase
			if (lv <= 0) begin
				lv = 0;
				if (m != MODE_STANDBY)
					halted[i] = 1'b1;
				m = MODE_STANDBY;
			end else if (lv >= FULL_SCALE) begin
				lv = FULL_SCALE;
				m  = MODE_PLAY;
			end
			ch_level[i] = lv;
			ch_mode[i]  = m;
		end
	endtask

	task automatic switch_track(input logic [IN_DATA_W-1:0] d);
		logic [CH_W-1:0] trk;
		logic            sounding;
		trk = d[3:0];
		for (int i = 0; i < CHANNELS; i++) begin
			sounding = ch_level[i] > 0 || ch_mode[i] != MODE_STANDBY;
			if (ch_level[i] > 0)
				ch_mode[i] = d[5] ? MODE_FADE_OUT : MODE_STOP;
			if (d[7]) begin
				if (sounding)
					halted[i] = 1'b1;
				ch_level[i] = 0;
				ch_mode[i]  = MODE_STANDBY;
			end
		end
		if (d[4] && trk < CHANNELS) begin
			// a track that is still sounding is halted before it restarts
			if (ch_level[trk] > 0) begin
				halted[trk]   = 1'b1;
				ch_level[trk] = 0;
			end
			started[trk] = 1'b1;
			if (d[6]) begin
				ch_mode[trk]  = MODE_PLAY;
				ch_level[trk] = FULL_SCALE;
			end else begin
				ch_mode[trk] = MODE_FADE_IN;
			end
		end
	endtask

	task automatic predict_channel_gains(input logic cmd, input logic [IN_DATA_W-1:0] d);
		int           scale;
		int           g;
		chan_report_t r;
		for (int i = 0; i < CHANNELS; i++) begin
			halted[i]  = 1'b0;
			started[i] = 1'b0;
		end
		if (cmd)
			switch_track(d);
		else
			advance_fades();
		scale = 255 * master_pct / 100;
		for (int i = 0; i < REPORTED; i++) begin
			g = scale * ch_level[i] / FULL_SCALE;
			if (g > 255)
				g = 255;
			r.channel = i[CH_W-1:0];
			r.gain    = g[GAIN_W-1:0];
			r.mode    = ch_mode[i];
			r.halted  = halted[i];
			r.started = started[i];
			r.last    = (i == REPORTED - 1);
			gain_reports.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		chan_report_t want;
		if (!arst_n) begin
			rise_step  = FADE_IN_RST;
			fall_step  = FADE_OUT_RST;
			halt_step  = STOP_RST;
			master_pct = MASTER_RST;
			for (int i = 0; i < CHANNELS; i++) begin
				ch_mode[i]  = MODE_STANDBY;
				ch_level[i] = 0;
			end
			gain_reports.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (gain_reports.size() == 0) begin
					$error("result beat with nothing expected: data %h last %b",
						m_axis_tdata, m_axis_tlast);
					mismatches++;
				end else begin
					want = gain_reports.pop_front();
					check_field("channel", want.channel, m_axis_tdata[3:0]);
					check_field("gain", want.gain, m_axis_tdata[11:4]);
					check_field("mode", int'(want.mode), m_axis_tdata[14:12]);
					check_field("stop_event", want.halted, m_axis_tdata[15]);
					check_field("start_event", want.started, m_axis_tdata[16]);
					check_field("last", want.last, m_axis_tlast);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_channel_gains(s_axis_tuser, s_axis_tdata);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FADE_IN_STEP:  rise_step  = cfg_data;
					CFG_FADE_OUT_STEP: fall_step  = cfg_data;
					CFG_STOP_STEP:     halt_step  = cfg_data;
					CFG_MASTER:        master_pct = cfg_data[MP_W-1:0];
					default: ;
				endcase
			end
			outstanding = gain_reports.size();
		end
	end

endmodule

// ===== test/tb_multi_channel_volume_fader.sv =====
// Stimulus and verdict for the multi-channel volume fader: drives ticks, play
// commands and register writes. Depends on mcvf_pkg, the fader and mcvf_checker.
`timescale 1ns / 1ps

module tb_multi_channel_volume_fader;
	import mcvf_pkg::*;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_PLAY = 1'b1;
	localparam int   SETTLE   = 40;
	localparam int   HOLD_OFF = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;

	bit tx_gaps;
	bit rx_gaps;
	int choke_req;

	multi_channel_volume_fader dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	mcvf_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random stalls, plus one long hold-off per request.
	initial begin
		int hold_left;
		int served;
		hold_left = 0;
		served = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (choke_req > served) begin
				served++;
				hold_left = HOLD_OFF;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_gaps) begin
				m_axis_tready <= ($urandom_range(99) >= 33);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic logic [IN_DATA_W-1:0] play_word(logic [CH_W-1:0] trk, logic go,
			logic soft_out, logic instant, logic cut);
		return {cut, instant, soft_out, go, trk};
	endfunction

	// Entered and left at a falling edge.
	task automatic push_beat(input logic cmd, input logic [IN_DATA_W-1:0] d);
		if (tx_gaps) begin
			while ($urandom_range(99) < 33) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_ramps(input logic [CFG_DATA_W-1:0] rise, fall, halt, master);
		write_reg(CFG_FADE_IN_STEP, rise);
		write_reg(CFG_FADE_OUT_STEP, fall);
		write_reg(CFG_STOP_STEP, halt);
		write_reg(CFG_MASTER, master);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, let every report come back, then let the block settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Mostly ticks so that fades run their course, with play commands mixed in.
	task automatic random_beats(input int count, input bit choke);
		for (int n = 0; n < count; n++) begin
			if (choke && n == count / 3)
				choke_req++;
			if ($urandom_range(99) < 70)
				push_beat(CMD_TICK, IN_DATA_W'($urandom));
			else
				push_beat(CMD_PLAY, play_word(CH_W'($urandom_range(15)),
					$urandom_range(99) < 85, 1'($urandom_range(1)),
					1'($urandom_range(1)), $urandom_range(99) < 10));
		end
		drain();
	endtask

	initial begin
		#2000000;
		$display("tb_multi_channel_volume_fader NOT OK");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		tx_gaps       = 1'b1;
		rx_gaps       = 1'b1;
		choke_req     = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part on the reset settings
		push_beat(CMD_TICK, '0);
		push_beat(CMD_PLAY, play_word(4'd0, 1'b1, 1'b1, 1'b1, 1'b0));
		push_beat(CMD_TICK, '0);
		push_beat(CMD_PLAY, play_word(4'd15, 1'b1, 1'b1, 1'b0, 1'b0));
		// channel 15 is fading in at zero and must not be sent out
		push_beat(CMD_PLAY, play_word(4'd3, 1'b1, 1'b1, 1'b0, 1'b0));
		repeat (3) push_beat(CMD_TICK, '0);
		// restart a sounding track, fast stop for the rest
		push_beat(CMD_PLAY, play_word(4'd0, 1'b1, 1'b0, 1'b1, 1'b0));
		push_beat(CMD_TICK, '0);
		push_beat(CMD_PLAY, play_word(4'd3, 1'b1, 1'b0, 1'b0, 1'b0));
		repeat (3) push_beat(CMD_TICK, '0);
		push_beat(CMD_PLAY, play_word(4'd7, 1'b1, 1'b0, 1'b1, 1'b1));
		push_beat(CMD_PLAY, play_word(4'd2, 1'b0, 1'b1, 1'b0, 1'b1));
		push_beat(CMD_PLAY, play_word(4'd9, 1'b1, 1'b1, 1'b0, 1'b0));
		push_beat(CMD_PLAY, play_word(4'd0, 1'b0, 1'b1, 1'b0, 1'b0));
		repeat (3) push_beat(CMD_TICK, '1);
		push_beat(CMD_PLAY, '1);
		push_beat(CMD_TICK, '0);
		push_beat(CMD_PLAY, play_word(4'd9, 1'b1, 1'b0, 1'b0, 1'b0));
		repeat (3) push_beat(CMD_TICK, '0);
		drain();

		set_ramps(9'd1, 9'd1, 9'd1, 9'd100);
		random_beats(60, 1'b0);

		set_ramps(9'd256, 9'd256, 9'd256, 9'd0);
		random_beats(50, 1'b0);

		// zero steps: fades never move
		set_ramps(9'd0, 9'd0, 9'd0, 9'd127);
		random_beats(40, 1'b0);

		// no idling on either side; master carries stray upper bits
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		set_ramps(9'd511, 9'd3, 9'd7, 9'h1FF);
		random_beats(50, 1'b0);
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;

		set_ramps(9'd17, 9'd5, 9'd40, 9'd73);
		random_beats(100, 1'b1);

		set_ramps(9'd4, 9'd2, 9'd32, 9'd50);
		random_beats(40, 1'b1);

		if (mismatches == 0 && outstanding == 0)
			$display("tb_multi_channel_volume_fader OK");
		else
			$display("tb_multi_channel_volume_fader NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mcvf_pkg.sv
rtl/mcvf_front.sv
rtl/mcvf_back.sv
rtl/mcvf_gain.sv
rtl/multi_channel_volume_fader.sv
test/mcvf_checker.sv
test/tb_multi_channel_volume_fader.sv
